// ===== rtl/axis_ownership_arbiter_macros.svh =====
// Assertion macros shared by the axis ownership arbiter modules.
`ifndef AXIS_OWNERSHIP_ARBITER_MACROS_SVH
`define AXIS_OWNERSHIP_ARBITER_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, ignored while reset is high.
`define AOA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("axis ownership arbiter assertion failed");

// Checked property that also holds during reset.
`define AOA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("axis ownership arbiter assertion failed");

`else

`define AOA_ASSERT(label, clk, rst, prop)

`define AOA_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/aoa_pkg.sv =====
// Types, constants and helper functions for the axis ownership arbiter.
package aoa_pkg;

  localparam int MAX_MODULES = 16;
  localparam int VEL_WIDTH   = 32;
  localparam int NUM_AXES    = 6;
  localparam int ID_W        = 4;
  localparam int AXIS_W      = 3;
  localparam int OUT_W       = 32;
  // Number of incoming velocity bits that survive the cut to VEL_WIDTH.
  localparam int VEL_KEEP    = (VEL_WIDTH < OUT_W) ? VEL_WIDTH : OUT_W;

  typedef enum logic {
    OP_REPLY     = 1'b0,
    OP_END_ROUND = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     operation;
    logic [ID_W-1:0]         module_id;
    logic                    finished;
    logic                    seize_req;
    logic [AXIS_W-1:0]       axis;
    logic signed [OUT_W-1:0] velocity;
  } item_t;

  typedef logic signed [OUT_W-1:0] vel_t;

  typedef struct packed {
    vel_t [NUM_AXES-1:0] vel;
  } result_t;

  // Cut to VEL_WIDTH bits and sign-extend back to the full word.
  function automatic vel_t fit_velocity(input vel_t raw);
    vel_t v;
    for (int i = 0; i < OUT_W; i++) begin
      if (i < VEL_KEEP) begin
        v[i] = raw[i];
      end else begin
        v[i] = raw[VEL_KEEP-1];
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/axis_ownership_arbiter.sv =====
// An end-of-round item is held in the input register, then its result is loaded into the
// result register, from which the output transfer is made.
// Throughput: one item per cycle; replies never wait, an end-of-round item waits in the
// input register while a previous result is stalled downstream.
// Reset (rst, synchronous): all axes free, round velocities zero, first-come mode,
// both pipeline registers empty. Configuration writes are taken every cycle.
module axis_ownership_arbiter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic [3:0]          module_id,
  input  logic                finished,
  input  logic                seize_req,
  input  logic [2:0]          axis,
  input  logic signed [31:0]  velocity,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  lin_vel_x,
  output logic signed [31:0]  lin_vel_y,
  output logic signed [31:0]  lin_vel_z,
  output logic signed [31:0]  ang_vel_x,
  output logic signed [31:0]  ang_vel_y,
  output logic signed [31:0]  ang_vel_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                takeover_sel
);
  import aoa_pkg::*;

  logic    prio_mode;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  logic    out_space;
  logic    emit;
  result_t core_result;
  result_t out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      prio_mode <= takeover_sel;
    end
  end

  assign in_item.operation = op_t'(operation);
  assign in_item.module_id = module_id;
  assign in_item.finished  = finished;
  assign in_item.seize_req = seize_req;
  assign in_item.axis      = axis;
  assign in_item.velocity  = velocity;

  // Replies never wait; an end-of-round item waits for room in the result register.
  assign advance = item_valid && (item.operation == OP_REPLY || out_space);
  assign fire    = advance;
  assign emit    = advance && item.operation == OP_END_ROUND;

  aoa_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  aoa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .prio_mode (prio_mode),
    .result    (core_result)
  );

  aoa_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_data (core_result),
    .space     (out_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (out_data)
  );

  assign lin_vel_x = out_data.vel[0];
  assign lin_vel_y = out_data.vel[1];
  assign lin_vel_z = out_data.vel[2];
  assign ang_vel_x = out_data.vel[3];
  assign ang_vel_y = out_data.vel[4];
  assign ang_vel_z = out_data.vel[5];

endmodule

// ===== rtl/aoa_in_reg.sv =====
// Input register stage: captures one item per transfer and holds it until used.
module aoa_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  aoa_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output aoa_pkg::item_t item
);
  import aoa_pkg::*;

  logic load;

  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/aoa_core.sv =====
// Owner table and round velocity store, updated by one item per cycle on each cycle that fire is high.
`include "axis_ownership_arbiter_macros.svh"

module aoa_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  aoa_pkg::item_t  item,
  input  logic            prio_mode,
  output aoa_pkg::result_t result
);
  import aoa_pkg::*;

  logic [NUM_AXES-1:0]            owner_valid, owner_valid_next;
  logic [NUM_AXES-1:0][ID_W-1:0]  owner_module, owner_module_next;
  vel_t [NUM_AXES-1:0]            round_vel, round_vel_next;

  logic id_ok;
  logic axis_ok;
  logic free_or_own;
  logic claim;
  logic write_vel;
  vel_t vel_fit;

  assign id_ok   = int'(item.module_id) < MAX_MODULES;
  assign axis_ok = int'(item.axis) < NUM_AXES;
  assign vel_fit = fit_velocity(item.velocity);

  always_comb begin
    free_or_own = 1'b0;
    if (axis_ok) begin
      free_or_own = !owner_valid[item.axis] || (owner_module[item.axis] == item.module_id);
    end
    claim     = 1'b0;
    write_vel = 1'b0;
    if (prio_mode) begin
      claim     = item.seize_req;
      write_vel = item.seize_req || free_or_own;
    end else begin
      claim     = free_or_own;
      write_vel = free_or_own;
    end
  end

  always_comb begin
    owner_valid_next  = owner_valid;
    owner_module_next = owner_module;
    round_vel_next    = round_vel;
    if (fire) begin
      if (item.operation == OP_END_ROUND) begin
        round_vel_next = '0;
      end else if (id_ok) begin
        if (item.finished) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (owner_valid[i] && owner_module[i] == item.module_id) begin
              owner_valid_next[i]  = 1'b0;
              owner_module_next[i] = '0;
            end
          end
        end else if (axis_ok) begin
          if (claim) begin
            owner_valid_next[item.axis]  = 1'b1;
            owner_module_next[item.axis] = item.module_id;
          end
          if (write_vel) begin
            round_vel_next[item.axis] = vel_fit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid  <= '0;
      owner_module <= '0;
      round_vel    <= '0;
    end else begin
      owner_valid  <= owner_valid_next;
      owner_module <= owner_module_next;
      round_vel    <= round_vel_next;
    end
  end

  assign result.vel = round_vel;

  `AOA_ASSERT(a_round_cleared, clk, rst,
    fire && item.operation == OP_END_ROUND |=> round_vel == '0)

  `AOA_ASSERT(a_priority_seize, clk, rst,
    fire && item.operation == OP_REPLY && !item.finished && axis_ok && prio_mode
      && item.seize_req
      |=> owner_valid[$past(item.axis)]
      && owner_module[$past(item.axis)] == $past(item.module_id))

  `AOA_ASSERT(a_first_come_keeps, clk, rst,
    fire && item.operation == OP_REPLY && !item.finished && axis_ok && !prio_mode
      && owner_valid[item.axis] && owner_module[item.axis] != item.module_id
      |=> $stable(owner_module) && $stable(owner_valid) && $stable(round_vel))

endmodule

// ===== rtl/aoa_out_reg.sv =====
// Result register: holds the round velocities until the downstream transfer.
`include "axis_ownership_arbiter_macros.svh"

module aoa_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  aoa_pkg::result_t load_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_stall,
  output aoa_pkg::result_t data
);
  import aoa_pkg::*;

  assign space = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  // A new result is only loaded when the previous one is gone or leaving.
  `AOA_ASSERT(a_no_overwrite, clk, rst, load |-> space)

  `AOA_ASSERT(a_load_shows, clk, rst, load |=> out_valid && data == $past(load_data))

  `AOA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

// ===== verif/aoa_checker.sv =====
`timescale 1ns / 100ps
// Checker for the axis ownership arbiter: tracks axis owners and compares each round's velocities.
module aoa_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               operation,
  input  logic [3:0]         module_id,
  input  logic               finished,
  input  logic               seize_req,
  input  logic [2:0]         axis,
  input  logic signed [31:0] velocity,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] lin_vel_x,
  input  logic signed [31:0] lin_vel_y,
  input  logic signed [31:0] lin_vel_z,
  input  logic signed [31:0] ang_vel_x,
  input  logic signed [31:0] ang_vel_y,
  input  logic signed [31:0] ang_vel_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               takeover_sel,
  output int                 errors,
  output int                 pending
);
  import aoa_pkg::*;

  logic            axis_owned [NUM_AXES];
  logic [ID_W-1:0] axis_owner [NUM_AXES];
  vel_t            round_vel  [NUM_AXES];
  logic            takeover_mode;
  result_t         round_cmd_q [$];
  int              mismatch_count = 0;

  function automatic string axis_name(input int idx);
    case (idx)
      0: return "lin_vel_x";
      1: return "lin_vel_y";
      2: return "lin_vel_z";
      3: return "ang_vel_x";
      4: return "ang_vel_y";
      default: return "ang_vel_z";
    endcase
  endfunction

  // Keep the low VEL_KEEP bits and sign-extend them back to a full word.
  function automatic vel_t narrow_velocity(input vel_t raw);
    vel_t v;
    v = raw <<< (OUT_W - VEL_KEEP);
    v = v >>> (OUT_W - VEL_KEEP);
    return v;
  endfunction

  task automatic arbitrate(input op_t op, input logic [ID_W-1:0] id, input logic fin,
                           input logic flag, input logic [AXIS_W-1:0] ax, input vel_t vel);
    result_t cmd;
    logic    free_or_own;
    if (op == OP_END_ROUND) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cmd.vel[i]   = round_vel[i];
        round_vel[i] = '0;
      end
      round_cmd_q = {round_cmd_q, cmd};
    end else if (id < MAX_MODULES) begin
      if (fin) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (axis_owned[i] && axis_owner[i] == id) begin
            axis_owned[i] = 1'b0;
            axis_owner[i] = '0;
          end
        end
      end else if (ax < NUM_AXES) begin
        free_or_own = !axis_owned[ax] || axis_owner[ax] == id;
        if (takeover_mode) begin
          // A flagged reply seizes the axis; an unflagged one writes, if the axis is free or its own, without claiming.
          if (flag) begin
            axis_owned[ax] = 1'b1;
            axis_owner[ax] = id;
            round_vel[ax]  = narrow_velocity(vel);
          end else if (free_or_own) begin
            round_vel[ax] = narrow_velocity(vel);
          end
        end else if (free_or_own) begin
          axis_owned[ax] = 1'b1;
          axis_owner[ax] = id;
          round_vel[ax]  = narrow_velocity(vel);
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_owned[i] = 1'b0;
        axis_owner[i] = '0;
        round_vel[i]  = '0;
      end
      takeover_mode = 1'b0;
      round_cmd_q.delete();
    end else begin
      // Results are checked before this edge's input transfer is predicted.
      if (out_valid && !out_stall) begin
        seen.vel[0] = lin_vel_x;
        seen.vel[1] = lin_vel_y;
        seen.vel[2] = lin_vel_z;
        seen.vel[3] = ang_vel_x;
        seen.vel[4] = ang_vel_y;
        seen.vel[5] = ang_vel_z;
        if (round_cmd_q.size() == 0) begin
          $error("velocity command transfer with no end of round pending");
          mismatch_count++;
        end else begin
          want = round_cmd_q.pop_front();
          for (int i = 0; i < NUM_AXES; i++) begin
            if (seen.vel[i] !== want.vel[i]) begin
              $error("%s: expected %0d, got %0d", axis_name(i), want.vel[i], seen.vel[i]);
              mismatch_count++;
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        takeover_mode = takeover_sel;
      end
      if (in_valid && !in_stall) begin
        arbitrate(op_t'(operation), module_id, finished, seize_req, axis, velocity);
      end
    end
    errors  <= mismatch_count;
    pending <= round_cmd_q.size();
  end

endmodule

// ===== verif/tb_axis_ownership_arbiter.sv =====
`timescale 1ns / 100ps
// Testbench top for the axis ownership arbiter: stimulus, flow control and verdict.
module tb_axis_ownership_arbiter;
  import aoa_pkg::*;

  localparam vel_t VEL_MAX = 32'sh7FFF_FFFF;
  localparam vel_t VEL_MIN = 32'sh8000_0000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               operation;
  logic [3:0]         module_id;
  logic               finished;
  logic               seize_req;
  logic [2:0]         axis;
  logic signed [31:0] velocity;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] lin_vel_x;
  logic signed [31:0] lin_vel_y;
  logic signed [31:0] lin_vel_z;
  logic signed [31:0] ang_vel_x;
  logic signed [31:0] ang_vel_y;
  logic signed [31:0] ang_vel_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               takeover_sel;

  int fail_count;
  int rounds_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;

  axis_ownership_arbiter uut (.*);

  aoa_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .module_id(module_id), .finished(finished),
    .seize_req(seize_req), .axis(axis), .velocity(velocity),
    .out_valid(out_valid), .out_stall(out_stall),
    .lin_vel_x(lin_vel_x), .lin_vel_y(lin_vel_y), .lin_vel_z(lin_vel_z),
    .ang_vel_x(ang_vel_x), .ang_vel_y(ang_vel_y), .ang_vel_z(ang_vel_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .takeover_sel(takeover_sel),
    .errors(fail_count), .pending(rounds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send(input op_t op, input logic [3:0] id, input logic fin, input logic flag,
                      input logic [2:0] ax, input vel_t vel);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation <= op;
    module_id <= id;
    finished  <= fin;
    seize_req <= flag;
    axis      <= ax;
    velocity  <= vel;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Replies mostly come from a few modules so that they contend for the same axes.
  task automatic send_random();
    op_t        op;
    logic [3:0] id;
    logic [2:0] ax;
    vel_t       vel;
    op = ($urandom_range(0, 99) < 12) ? OP_END_ROUND : OP_REPLY;
    id = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    ax = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    case ($urandom_range(0, 9))
      0: vel = VEL_MAX;
      1: vel = VEL_MIN;
      2: vel = '0;
      default: vel = vel_t'($urandom);
    endcase
    send(op, id, ($urandom_range(0, 99) < 10), 1'($urandom_range(0, 1)), ax, vel);
  endtask

  // The mode register is written only once no round is outstanding and the pipeline is empty.
  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rounds_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    takeover_sel <= m;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase;
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = OP_REPLY;
    module_id    = '0;
    finished     = 1'b0;
    seize_req    = 1'b0;
    axis         = '0;
    velocity     = '0;
    cfg_valid    = 1'b0;
    takeover_sel = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // First-come mode from reset.
    send(OP_END_ROUND, 4'd0, 1'b0, 1'b0, 3'd0, '0);
    send(OP_REPLY, 4'd0, 1'b0, 1'b0, 3'd0, VEL_MAX);
    send(OP_REPLY, 4'd15, 1'b0, 1'b0, 3'd0, 32'sd5);
    send(OP_REPLY, 4'd15, 1'b0, 1'b0, 3'd5, VEL_MIN);
    send(OP_REPLY, 4'd0, 1'b0, 1'b0, 3'd0, -32'sd1);
    send(OP_REPLY, 4'd3, 1'b0, 1'b0, 3'd6, 32'sd7);
    send(OP_REPLY, 4'd3, 1'b0, 1'b1, 3'd7, 32'sd9);
    send(OP_END_ROUND, 4'd15, 1'b1, 1'b1, 3'd7, VEL_MAX);
    send(OP_REPLY, 4'd0, 1'b1, 1'b0, 3'd7, '0);
    send(OP_REPLY, 4'd15, 1'b0, 1'b1, 3'd0, 32'sd1);
    send(OP_REPLY, 4'd9, 1'b0, 1'b0, 3'd5, 32'sd2);
    send(OP_END_ROUND, 4'd0, 1'b0, 1'b0, 3'd0, '0);

    // Priority takeover mode.
    set_mode(1'b1);
    send(OP_REPLY, 4'd2, 1'b0, 1'b0, 3'd0, 32'sd11);
    send(OP_REPLY, 4'd2, 1'b0, 1'b1, 3'd0, VEL_MIN);
    send(OP_REPLY, 4'd15, 1'b0, 1'b0, 3'd0, 32'sd13);
    send(OP_REPLY, 4'd7, 1'b0, 1'b0, 3'd3, 32'sd14);
    send(OP_REPLY, 4'd8, 1'b0, 1'b0, 3'd3, VEL_MAX);
    send(OP_REPLY, 4'd2, 1'b0, 1'b1, 3'd6, 32'sd15);
    send(OP_REPLY, 4'd4, 1'b0, 1'b1, 3'd4, -32'sd16);
    send(OP_END_ROUND, 4'd0, 1'b0, 1'b0, 3'd0, '0);
    send(OP_REPLY, 4'd2, 1'b1, 1'b1, 3'd7, '0);
    send(OP_REPLY, 4'd15, 1'b0, 1'b0, 3'd0, 32'sd17);
    send(OP_END_ROUND, 4'd0, 1'b0, 1'b0, 3'd0, '0);

    for (phase = 0; phase < 8; phase++) begin
      set_mode(phase[0]);
      case (phase / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 64;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct     = 23;
        end
      endcase
      repeat (165) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (rounds_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && rounds_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aoa_pkg.sv
rtl/aoa_in_reg.sv
rtl/aoa_core.sv
rtl/aoa_out_reg.sv
rtl/axis_ownership_arbiter.sv
verif/aoa_checker.sv
verif/tb_axis_ownership_arbiter.sv
